>>> rtl/gsms_pkg.sv
// gsms_pkg: shared widths, phase/kind/mode codes, command and status types
// of the gas sensor measurement sequencer
// no dependencies
`default_nettype none

package gsms_pkg;

    // default parameter values
    localparam int ADC_BITS_DEF   = 12;
    localparam int TIMEOUT_MS_DEF = 2000;

    // fixed widths
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 16;
    localparam int SUM_W     = 28;
    localparam int TIME_W    = 32;
    localparam int RPM_W     = 16;
    localparam int PHASE_W   = 3;
    localparam int KIND_W    = 3;
    localparam int MODE_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_MIN  = 3'd4;

    // configuration reset values
    localparam logic [CFG_W-1:0] WAIT_RST     = 16'd60;
    localparam logic [CFG_W-1:0] EXPOSURE_RST = 16'd30;
    localparam logic [CFG_W-1:0] TEMP_RST     = 16'd4;
    localparam logic [CFG_W-1:0] CONC_RST     = 16'd10;
    localparam logic [CFG_W-1:0] FAN_MIN_RST  = 16'd1000;

    // sequence phases
    localparam logic [PHASE_W-1:0] PH_INIT   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXPOSE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TEMP   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CONC   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SLEEP  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_CCONC  = 3'd6;
    localparam logic [PHASE_W-1:0] PH_CTEMP  = 3'd7;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_OFFSET = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TEMP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CONC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CAL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CCONC  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CTEMP  = 3'd5;

    // front-end modes
    localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AMP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEMP  = 2'd2;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_DEC,
        CNT_WAIT,
        CNT_EXPOSURE,
        CNT_TEMP,
        CNT_CONC
    } cnt_op_t;

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_CLR,
        SUM_ADD
    } sum_op_t;

    typedef enum logic [1:0] {
        DIV_WAIT,
        DIV_TEMP,
        DIV_CONC
    } div_sel_t;

    typedef enum logic [1:0] {
        VAL_NONE,
        VAL_ADC,
        VAL_AVG
    } val_sel_t;

    // controller to datapath
    typedef struct packed {
        logic                in_ready;
        cnt_op_t             cnt_op;
        sum_op_t             sum_op;
        logic                mark_load;
        logic                div_start;
        div_sel_t            div_sel;
        logic                out_load;
        logic [PHASE_W-1:0]  phase;
        logic                fan_on;
        logic [MODE_W-1:0]   mode;
        logic                res_valid;
        logic [KIND_W-1:0]   kind;
        val_sel_t            val_sel;
        logic                afe_fault;
        logic                fan_fault;
        logic                cal_end;
    } gsms_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic cnt_zero;
        logic timed_out;
        logic rpm_low;
        logic rpm_nonzero;
        logic wait_zero;
        logic cal;
        logic afe_ready;
        logic div_busy;
        logic out_blocked;
    } gsms_stat_t;

endpackage

`default_nettype wire

>>> rtl/gsms_item_if.sv
// gsms_item_if: input item channel, one item per one-second tick
// depends on gsms_pkg
`default_nettype none

interface gsms_item_if
    import gsms_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_sample;
    logic [TIME_W-1:0]   now_ms;
    logic [RPM_W-1:0]    fan_rpm;
    logic                cal_request;
    logic                afe_ready;

    modport source (
        output valid, adc_sample, now_ms, fan_rpm, cal_request, afe_ready,
        input  ready
    );

    modport sink (
        input  valid, adc_sample, now_ms, fan_rpm, cal_request, afe_ready,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/gsms_result_if.sv
// gsms_result_if: result channel, one result per input item
// depends on gsms_pkg
`default_nettype none

interface gsms_result_if
    import gsms_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic [PHASE_W-1:0]  phase;
    logic                fan_on;
    logic [MODE_W-1:0]   frontend_mode;
    logic                result_valid;
    logic [KIND_W-1:0]   result_kind;
    logic [ADC_BITS-1:0] result_value;
    logic                frontend_fault;
    logic                fan_fault;
    logic                cal_end;

    modport source (
        output valid, phase, fan_on, frontend_mode, result_valid, result_kind,
               result_value, frontend_fault, fan_fault, cal_end,
        input  ready
    );

    modport sink (
        input  valid, phase, fan_on, frontend_mode, result_valid, result_kind,
               result_value, frontend_fault, fan_fault, cal_end,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/gas_sensor_measure_sequencer.sv
// gas_sensor_measure_sequencer: top level, sequence controller plus datapath
// depends on gsms_pkg, gsms_item_if, gsms_result_if, gsms_ctrl, gsms_datapath
`default_nettype none

// One item is taken per one-second tick and gives exactly one result. The
// block works on one item at a time. A step without an average evaluates the
// item and then loads the result register. A step that closes an averaging
// phase also runs the restoring divider before its result load; the divider
// produces one quotient bit per cycle. The next item is taken as soon as the
// result register is loaded, even while that result still waits for its
// transfer. That next step then holds before its own result load until the
// waiting result is taken. Configuration registers must be written by the
// user through the plain write port while no item is in flight; the block
// itself does not enforce this. Indexes past the last register are ignored.
module gas_sensor_measure_sequencer
    import gsms_pkg::*;
#(
    parameter int          ADC_BITS   = ADC_BITS_DEF,
    parameter int unsigned TIMEOUT_MS = TIMEOUT_MS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    gsms_item_if.sink                 item,
    gsms_result_if.source             result
);
    gsms_cmd_t  cmd;
    gsms_stat_t stat;

    // sequence controller
    gsms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // counters, sum, divider and result register
    gsms_datapath #(
        .ADC_BITS   (ADC_BITS),
        .TIMEOUT_MS (TIMEOUT_MS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .result    (result),
        .cmd       (cmd),
        .stat      (stat)
    );
endmodule

`default_nettype wire

>>> rtl/gsms_divider.sv
// gsms_divider: restoring divider, one quotient bit per cycle
// depends on gsms_pkg
`default_nettype none

module gsms_divider
    import gsms_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CFG_W-1:0] divisor,
    output logic                  busy,
    output logic                  div_zero,
    output logic [SUM_W-1:0]      quotient
);
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CFG_W-1:0]  dvs_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic              zero_reg;

    logic [CFG_W:0]    shifted;
    logic [CFG_W+1:0]  diff;
    logic              fits;

    // trial subtraction of the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = ~diff[CFG_W+1];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= LAST_STEP;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg  <= divisor;
            zero_reg <= (divisor == '0);
            rem_reg  <= '0;
            quo_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign div_zero = zero_reg;
    assign quotient = quo_reg;
endmodule

`default_nettype wire

>>> rtl/gsms_datapath.sv
// gsms_datapath: configuration registers, input latch, countdown, sample sum,
// time mark, averaging divider and result register
// depends on gsms_pkg, gsms_item_if, gsms_result_if, gsms_divider
`default_nettype none

module gsms_datapath
    import gsms_pkg::*;
#(
    parameter int          ADC_BITS   = ADC_BITS_DEF,
    parameter int unsigned TIMEOUT_MS = TIMEOUT_MS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    gsms_item_if.sink                 item,
    gsms_result_if.source             result,
    input  wire gsms_cmd_t            cmd,
    output gsms_stat_t                stat
);
    localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};
    localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [TIME_W-1:0]   TIMEOUT    = TIME_W'(TIMEOUT_MS);

    logic [CFG_W-1:0] wait_reg, exposure_reg, temp_reg, conc_reg, fan_min_reg;

    logic [ADC_BITS-1:0] adc_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [RPM_W-1:0]    rpm_reg;
    logic                cal_reg;
    logic                afe_ready_reg;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [TIME_W-1:0] mark_reg;

    logic [SUM_W:0]      sum_add;
    logic [TIME_W-1:0]   elapsed;
    logic                in_load;
    logic [CFG_W-1:0]    divisor;
    logic                div_busy, div_zero;
    logic [SUM_W-1:0]    quotient;
    logic [ADC_BITS-1:0] average;
    logic [ADC_BITS-1:0] value;

    logic                out_valid_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic                fan_on_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic                res_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [ADC_BITS-1:0] value_reg;
    logic                afe_fault_reg;
    logic                fan_fault_reg;
    logic                cal_end_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg     <= WAIT_RST;
            exposure_reg <= EXPOSURE_RST;
            temp_reg     <= TEMP_RST;
            conc_reg     <= CONC_RST;
            fan_min_reg  <= FAN_MIN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WAIT:     wait_reg     <= cfg_wdata;
                CFG_EXPOSURE: exposure_reg <= cfg_wdata;
                CFG_TEMP:     temp_reg     <= cfg_wdata;
                CFG_CONC:     conc_reg     <= cfg_wdata;
                CFG_FAN_MIN:  fan_min_reg  <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // input transfer latch
    assign in_load    = item.valid & cmd.in_ready;
    assign item.ready = cmd.in_ready;

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            adc_reg       <= item.adc_sample;
            now_reg       <= item.now_ms;
            rpm_reg       <= item.fan_rpm;
            cal_reg       <= item.cal_request;
            afe_ready_reg <= item.afe_ready;
        end
    end

    // countdown and saturating sample sum
    always_comb
    begin
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(adc_reg);

        case (cmd.cnt_op)
            CNT_DEC:      cnt_next = cnt_reg - 1'b1;
            CNT_WAIT:     cnt_next = wait_reg;
            CNT_EXPOSURE: cnt_next = exposure_reg;
            CNT_TEMP:     cnt_next = temp_reg;
            CNT_CONC:     cnt_next = conc_reg;
            default:      cnt_next = cnt_reg;
        endcase

        case (cmd.sum_op)
            SUM_CLR: sum_next = '0;
            SUM_ADD: sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            default: sum_next = sum_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            mark_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            if (cmd.mark_load)
            begin
                mark_reg <= now_reg;
            end
        end
    end

    // averaging divider, dividend taken before this step's sum update
    always_comb
    begin
        case (cmd.div_sel)
            DIV_TEMP: divisor = temp_reg;
            DIV_CONC: divisor = conc_reg;
            default:  divisor = wait_reg;
        endcase
    end

    gsms_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .div_zero (div_zero),
        .quotient (quotient)
    );

    // saturated average and result value select
    always_comb
    begin
        if (div_zero || (quotient > SUM_W'(FULL_SCALE)))
        begin
            average = FULL_SCALE;
        end
        else
        begin
            average = quotient[ADC_BITS-1:0];
        end

        case (cmd.val_sel)
            VAL_ADC: value = adc_reg;
            VAL_AVG: value = average;
            default: value = '0;
        endcase
    end

    // status to controller
    assign elapsed = now_reg - mark_reg;

    always_comb
    begin
        stat.in_valid    = item.valid;
        stat.cnt_zero    = (cnt_reg == '0);
        stat.timed_out   = (elapsed > TIMEOUT);
        stat.rpm_low     = (rpm_reg < fan_min_reg);
        stat.rpm_nonzero = (rpm_reg != '0);
        stat.wait_zero   = (wait_reg == '0);
        stat.cal         = cal_reg;
        stat.afe_ready   = afe_ready_reg;
        stat.div_busy    = div_busy;
        stat.out_blocked = out_valid_reg & ~result.ready;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            phase_reg     <= cmd.phase;
            fan_on_reg    <= cmd.fan_on;
            mode_reg      <= cmd.mode;
            res_valid_reg <= cmd.res_valid;
            kind_reg      <= cmd.kind;
            value_reg     <= value;
            afe_fault_reg <= cmd.afe_fault;
            fan_fault_reg <= cmd.fan_fault;
            cal_end_reg   <= cmd.cal_end;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.phase          = phase_reg;
    assign result.fan_on         = fan_on_reg;
    assign result.frontend_mode  = mode_reg;
    assign result.result_valid   = res_valid_reg;
    assign result.result_kind    = kind_reg;
    assign result.result_value   = value_reg;
    assign result.frontend_fault = afe_fault_reg;
    assign result.fan_fault      = fan_fault_reg;
    assign result.cal_end        = cal_end_reg;
endmodule

`default_nettype wire

>>> rtl/gsms_ctrl.sv
// gsms_ctrl: measurement sequence state machine and item handshake control
// depends on gsms_pkg
`default_nettype none

module gsms_ctrl
    import gsms_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire gsms_stat_t stat,
    output gsms_cmd_t       cmd
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } ctl_state_t;

    ctl_state_t         state_reg, state_next;
    logic [PHASE_W-1:0] seq_reg, seq_next;
    logic               fan_reg, fan_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic               ferr_reg, ferr_next;
    logic [PHASE_W-1:0] ran_reg, ran_next;
    logic               rvalid_reg, rvalid_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    val_sel_t           vsel_reg, vsel_next;
    logic               afe_reg, afe_next;
    logic               calend_reg, calend_next;

    logic               redirect;
    logic [PHASE_W-1:0] eff_phase;
    logic               cnt_done;

    // calibration request pulls the sequence into the wait phase
    always_comb
    begin
        redirect  = stat.cal && (seq_reg != PH_EXPOSE) && (seq_reg != PH_TEMP)
                    && (seq_reg != PH_CONC);
        eff_phase = redirect ? PH_WAIT : seq_reg;
        cnt_done  = stat.cnt_zero | redirect;
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        seq_next    = seq_reg;
        fan_next    = fan_reg;
        mode_next   = mode_reg;
        ferr_next   = ferr_reg;
        ran_next    = ran_reg;
        rvalid_next = rvalid_reg;
        kind_next   = kind_reg;
        vsel_next   = vsel_reg;
        afe_next    = afe_reg;
        calend_next = calend_reg;

        cmd           = '0;
        cmd.cnt_op    = CNT_HOLD;
        cmd.sum_op    = SUM_HOLD;
        cmd.div_sel   = DIV_WAIT;
        cmd.in_ready  = (state_reg == ST_IDLE);
        cmd.phase     = ran_reg;
        cmd.fan_on    = fan_reg;
        cmd.mode      = mode_reg;
        cmd.res_valid = rvalid_reg;
        cmd.kind      = kind_reg;
        cmd.val_sel   = vsel_reg;
        cmd.afe_fault = afe_reg;
        cmd.fan_fault = ferr_reg;
        cmd.cal_end   = calend_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                ran_next    = eff_phase;
                rvalid_next = 1'b0;
                kind_next   = KIND_OFFSET;
                vsel_next   = VAL_NONE;
                afe_next    = 1'b0;
                calend_next = 1'b0;
                seq_next    = eff_phase;

                unique case (eff_phase)
                    PH_INIT:
                    begin
                        if (stat.afe_ready)
                        begin
                            mode_next  = MODE_AMP;
                            cmd.sum_op = SUM_CLR;
                            cmd.cnt_op = CNT_WAIT;
                            seq_next   = PH_WAIT;
                        end
                        else if (stat.timed_out)
                        begin
                            afe_next = 1'b1;
                            seq_next = PH_SLEEP;
                        end
                    end

                    PH_WAIT:
                    begin
                        if (stat.wait_zero)
                        begin
                            cmd.cnt_op    = CNT_EXPOSURE;
                            cmd.mark_load = 1'b1;
                            seq_next      = PH_CCONC;
                        end
                        else if (cnt_done)
                        begin
                            fan_next      = 1'b1;
                            cmd.cnt_op    = CNT_EXPOSURE;
                            rvalid_next   = 1'b1;
                            kind_next     = KIND_OFFSET;
                            vsel_next     = VAL_AVG;
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = DIV_WAIT;
                            cmd.mark_load = 1'b1;
                            seq_next      = PH_EXPOSE;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_DEC;
                            cmd.sum_op = SUM_ADD;
                        end
                    end

                    PH_EXPOSE:
                    begin
                        if (stat.cnt_zero)
                        begin
                            fan_next      = 1'b0;
                            cmd.cnt_op    = CNT_TEMP;
                            cmd.sum_op    = SUM_CLR;
                            mode_next     = MODE_TEMP;
                            cmd.mark_load = 1'b1;
                            seq_next      = PH_TEMP;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_DEC;
                            if (stat.timed_out && stat.rpm_low)
                            begin
                                ferr_next = 1'b1;
                            end
                        end
                    end

                    PH_TEMP:
                    begin
                        // fan still turning: hold until the timeout, then flag
                        if (!stat.rpm_nonzero || stat.timed_out)
                        begin
                            if (stat.rpm_nonzero)
                            begin
                                ferr_next = 1'b1;
                            end
                            if (stat.cnt_zero)
                            begin
                                cmd.cnt_op    = CNT_CONC;
                                rvalid_next   = 1'b1;
                                kind_next     = KIND_TEMP;
                                vsel_next     = VAL_AVG;
                                cmd.div_start = 1'b1;
                                cmd.div_sel   = DIV_TEMP;
                                mode_next     = MODE_AMP;
                                cmd.sum_op    = SUM_CLR;
                                seq_next      = PH_CONC;
                            end
                            else
                            begin
                                cmd.cnt_op = CNT_DEC;
                                cmd.sum_op = SUM_ADD;
                            end
                        end
                    end

                    PH_CONC:
                    begin
                        if (stat.cnt_zero)
                        begin
                            rvalid_next   = 1'b1;
                            kind_next     = stat.cal ? KIND_CAL : KIND_CONC;
                            calend_next   = stat.cal;
                            vsel_next     = VAL_AVG;
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = DIV_CONC;
                            seq_next      = PH_SLEEP;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_DEC;
                            cmd.sum_op = SUM_ADD;
                        end
                    end

                    PH_CCONC:
                    begin
                        fan_next = 1'b1;
                        if (stat.timed_out)
                        begin
                            ferr_next = stat.rpm_low;
                        end
                        rvalid_next = 1'b1;
                        kind_next   = KIND_CCONC;
                        vsel_next   = VAL_ADC;
                        mode_next   = MODE_TEMP;
                        seq_next    = PH_CTEMP;
                    end

                    PH_CTEMP:
                    begin
                        rvalid_next = 1'b1;
                        kind_next   = KIND_CTEMP;
                        vsel_next   = VAL_ADC;
                        if (!stat.wait_zero)
                        begin
                            fan_next = 1'b0;
                            seq_next = PH_SLEEP;
                        end
                        else
                        begin
                            mode_next = MODE_AMP;
                            seq_next  = PH_CCONC;
                        end
                    end

                    // sleep
                    default:
                    begin
                        cmd.mark_load = 1'b1;
                        mode_next     = MODE_SLEEP;
                        seq_next      = PH_INIT;
                    end
                endcase

                state_next = cmd.div_start ? ST_DIV : ST_OUT;
            end

            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!stat.out_blocked)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered step outcome
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seq_reg    <= PH_SLEEP;
            fan_reg    <= 1'b0;
            mode_reg   <= MODE_SLEEP;
            ferr_reg   <= 1'b0;
            ran_reg    <= PH_SLEEP;
            rvalid_reg <= 1'b0;
            kind_reg   <= KIND_OFFSET;
            vsel_reg   <= VAL_NONE;
            afe_reg    <= 1'b0;
            calend_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seq_reg    <= seq_next;
            fan_reg    <= fan_next;
            mode_reg   <= mode_next;
            ferr_reg   <= ferr_next;
            ran_reg    <= ran_next;
            rvalid_reg <= rvalid_next;
            kind_reg   <= kind_next;
            vsel_reg   <= vsel_next;
            afe_reg    <= afe_next;
            calend_reg <= calend_next;
        end
    end
endmodule

`default_nettype wire

>>> rtl/gsms_checker.sv
// gsms_checker: port-level assertions on the sequencer, bound to the top level
// depends on gsms_pkg
`default_nettype none

module gsms_checker
    import gsms_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_ready,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire logic [PHASE_W-1:0]  phase,
    input wire logic                fan_on,
    input wire logic [MODE_W-1:0]   frontend_mode,
    input wire logic                result_valid,
    input wire logic [KIND_W-1:0]   result_kind,
    input wire logic [ADC_BITS-1:0] result_value,
    input wire logic                frontend_fault,
    input wire logic                cal_end
);
    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // an item transfer closes the input for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input reopened right after a transfer");

    // a result without a value carries zero kind and value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !result_valid |-> result_kind == KIND_OFFSET && result_value == '0)
        else $error("stale kind or value on an empty result");

    // calibration end comes only with the calibration concentration average
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && cal_end |-> result_valid && result_kind == KIND_CAL
                                 && phase == PH_CONC)
        else $error("calibration end without its result");

    // front-end fault only from init; continuous conversion drives fan and temp mode
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (frontend_fault || phase == PH_CCONC) |->
            (frontend_fault && phase == PH_INIT && !result_valid)
            || (phase == PH_CCONC && fan_on && frontend_mode == MODE_TEMP))
        else $error("fault or continuous-mode outputs inconsistent");
endmodule

bind gas_sensor_measure_sequencer gsms_checker #(
    .ADC_BITS (ADC_BITS)
) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .phase          (result.phase),
    .fan_on         (result.fan_on),
    .frontend_mode  (result.frontend_mode),
    .result_valid   (result.result_valid),
    .result_kind    (result.result_kind),
    .result_value   (result.result_value),
    .frontend_fault (result.frontend_fault),
    .cal_end        (result.cal_end)
);

`default_nettype wire
